### src/sbr_pkg.sv
// sbr_pkg: types, constants and the reciprocal table for the supersample box resolve
// depends on nothing; imported by every module of the block but sbr_ram
`default_nettype none
package sbr_pkg;

  localparam int MAX_SS    = 4;
  localparam int SS_W      = 2;   // sub_col / sub_row counters
  localparam int CFG_W     = 11;  // widest configuration register
  localparam int SUM_W     = 36;  // three 12-bit lanes
  localparam int LANE_W    = 12;
  localparam int RGB_W     = 24;
  localparam int QUEUE_D   = 4;
  localparam int QPTR_W    = 2;
  localparam int RECIP_W   = 17;
  localparam int RECIP_SH  = 17;
  localparam int DIVIN_W   = 13;  // 2*sum + n
  localparam int PROD_W    = DIVIN_W + RECIP_W;

  localparam logic [1:0] REG_SS     = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  localparam logic [CFG_W-1:0] RST_SS     = 11'd1;
  localparam logic [CFG_W-1:0] RST_WIDTH  = 11'd1024;
  localparam logic [CFG_W-1:0] RST_HEIGHT = 11'd1024;

  // column address is carried at the widest width a width parameter allows
  localparam int COL_MAX_W = 12;

  typedef struct packed {
    logic                 need_read;  // add the stored column sum
    logic                 emit;       // last subrow: produce a result
    logic                 last;       // final output of the frame
    logic [COL_MAX_W-1:0] col;
    logic [SUM_W-1:0]     sum;
  } cmd_t;

  typedef struct packed {
    logic at_origin;
    logic push;
  } front_stat_t;

  typedef struct packed {
    logic busy;
    logic showing;
  } back_stat_t;

  // ceil(2^17 / (2*n)), n = ss*ss; exact for every lane sum in range
  function automatic logic [RECIP_W-1:0] recip(input logic [2:0] ss);
    logic [RECIP_W-1:0] r;
    case (ss)
      3'd2:    r = 17'd16384;
      3'd3:    r = 17'd7282;
      3'd4:    r = 17'd4096;
      default: r = 17'd65536;
    endcase
    return r;
  endfunction

  function automatic logic [SUM_W-1:0] widen(input logic [RGB_W-1:0] rgb);
    return {4'd0, rgb[23:16], 4'd0, rgb[15:8], 4'd0, rgb[7:0]};
  endfunction

endpackage
`default_nettype wire

### src/sbr_ram.sv
// sbr_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none
module sbr_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 1024,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

### src/sbr_front.sv
// sbr_front: configuration registers, block position counters and subrow sums
// depends on sbr_pkg; pushes one command per finished block subrow
`default_nettype none
module sbr_front import sbr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  input  wire logic             cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             pixel_valid,
  input  wire logic [RGB_W-1:0] pixel_rgb,
  input  wire logic             q_full,
  output logic                  pixel_ready,
  output logic                  q_push,
  output cmd_t                  q_cmd,
  output logic [2:0]            ss_eff,
  output front_stat_t           stat
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [2:0]       ss_reg;
  logic [CFG_W-1:0] width_reg, height_reg;
  logic [SUM_W-1:0] run_sum, run_sum_next;
  logic [SS_W-1:0]  sub_col, sub_row;
  logic [CW-1:0]    out_col;
  logic [RW-1:0]    out_row;

  logic [WW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  logic          accept, cfg_write, col_last, row_last, oc_last, or_last;

  always_comb begin
    if (ss_reg == 3'd0) ss_eff = 3'd1;
    else if (32'(ss_reg) > MAX_SS) ss_eff = 3'(MAX_SS);
    else ss_eff = ss_reg;

    if (width_reg == '0) w_eff = WW'(1);
    else if (32'(width_reg) > MAX_WIDTH) w_eff = WW'(MAX_WIDTH);
    else w_eff = WW'(width_reg);

    if (height_reg == '0) h_eff = HW'(1);
    else if (32'(height_reg) > MAX_HEIGHT) h_eff = HW'(MAX_HEIGHT);
    else h_eff = HW'(height_reg);
  end

  assign accept    = pixel_valid && pixel_ready;
  assign cfg_write = cfg_valid && cfg_ready;
  assign col_last  = ({1'b0, sub_col} + 3'd1) >= ss_eff;
  assign row_last  = ({1'b0, sub_row} + 3'd1) >= ss_eff;
  assign oc_last   = (32'(out_col) + 32'd1) >= 32'(w_eff);
  assign or_last   = (32'(out_row) + 32'd1) >= 32'(h_eff);

  assign run_sum_next = (sub_col == '0) ? widen(pixel_rgb) : run_sum + widen(pixel_rgb);

  // pixels wait while the command queue is full or a register write is pending
  assign pixel_ready = !q_full && !cfg_valid;
  assign q_push      = accept && col_last;

  always_comb begin
    q_cmd.need_read = (sub_row != '0);
    q_cmd.emit      = row_last;
    q_cmd.last      = oc_last && or_last;
    q_cmd.col       = COL_MAX_W'(out_col);
    q_cmd.sum       = run_sum_next;
  end

  assign stat.at_origin = (sub_col == '0) && (sub_row == '0) && (out_col == '0)
                          && (out_row == '0) && (run_sum == '0);
  assign stat.push      = q_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      ss_reg     <= RST_SS[2:0];
      width_reg  <= RST_WIDTH;
      height_reg <= RST_HEIGHT;
      run_sum    <= '0;
      sub_col    <= '0;
      sub_row    <= '0;
      out_col    <= '0;
      out_row    <= '0;
    end else if (cfg_write) begin
      // any write to a known register restarts the frame
      if (cfg_index == REG_SS || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT) begin
        run_sum <= '0;
        sub_col <= '0;
        sub_row <= '0;
        out_col <= '0;
        out_row <= '0;
      end
      if (cfg_index == REG_SS) ss_reg <= cfg_data[2:0];
      if (cfg_index == REG_WIDTH) width_reg <= cfg_data;
      if (cfg_index == REG_HEIGHT) height_reg <= cfg_data;
    end else if (accept) begin
      run_sum <= run_sum_next;
      if (col_last) begin
        sub_col <= '0;
        if (oc_last) begin
          out_col <= '0;
          if (row_last) begin
            sub_row <= '0;
            out_row <= or_last ? '0 : out_row + RW'(1);
          end else begin
            sub_row <= sub_row + SS_W'(1);
          end
        end else begin
          out_col <= out_col + CW'(1);
        end
      end else begin
        sub_col <= sub_col + SS_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

### src/sbr_queue.sv
// sbr_queue: short command queue between the front and back parts
// depends on sbr_pkg for cmd_t and the queue depth
`default_nettype none
module sbr_queue import sbr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_cmd,
  input  wire logic pop,
  output cmd_t      head,
  output logic      empty,
  output logic      full
);

  cmd_t              slots [QUEUE_D];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0]   count;

  assign head  = slots[rd_ptr];
  assign empty = (count == '0);
  assign full  = (32'(count) == QUEUE_D);

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

endmodule
`default_nettype wire

### src/sbr_back.sv
// sbr_back: runs queued commands against the column store and averages blocks
// depends on sbr_pkg and sbr_ram
`default_nettype none
module sbr_back import sbr_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [2:0]       ss_eff,
  input  wire cmd_t             head,
  input  wire logic             q_empty,
  output logic                  q_pop,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [RGB_W-1:0]      avg_rgb,
  output logic                  frame_last,
  output back_stat_t            stat
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  localparam logic [1:0] B_IDLE = 2'd0;
  localparam logic [1:0] B_ADD  = 2'd1;
  localparam logic [1:0] B_OUT  = 2'd2;

  logic [1:0]       state, state_next;
  cmd_t             cur;
  logic [SUM_W-1:0] rd_data, total;
  logic [4:0]       n;
  logic [7:0]       lane_avg [3];
  logic             wr_en;

  sbr_ram #(.WIDTH(SUM_W), .DEPTH(MAX_WIDTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (cur.col[CW-1:0]),
    .wr_data (total),
    .rd_addr (head.col[CW-1:0]),
    .rd_data (rd_data)
  );

  assign q_pop = (state == B_IDLE) && !q_empty;
  assign total = cur.need_read ? rd_data + cur.sum : cur.sum;
  assign wr_en = (state == B_ADD) && !cur.emit;
  assign n     = 5'(ss_eff) * 5'(ss_eff);

  // per lane: floor((2*s + n) / (2*n)) by reciprocal multiply
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [DIVIN_W-1:0] x;
      logic [PROD_W-1:0]  p;
      x = {total[i*LANE_W +: LANE_W], 1'b0} + DIVIN_W'(n);
      p = PROD_W'(x) * PROD_W'(recip(ss_eff));
      lane_avg[i] = p[RECIP_SH +: 8];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (!q_empty) state_next = B_ADD;
      B_ADD:  state_next = cur.emit ? B_OUT : B_IDLE;
      B_OUT:  if (result_ready) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  assign result_valid = (state == B_OUT);
  assign stat.busy    = (state != B_IDLE);
  assign stat.showing = (state == B_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (state == B_ADD && cur.emit) begin
      avg_rgb    <= {lane_avg[2], lane_avg[1], lane_avg[0]};
      frame_last <= cur.last;
    end
  end

endmodule
`default_nettype wire

### src/supersample_box_resolve.sv
// result path: the queue, then B_ADD registers the average and B_OUT shows it; throughput:
// one pixel per cycle while the 4-deep command queue has room and no register write is
// pending; the back part passes B_IDLE and B_ADD per stored column sum, and B_OUT too per
// result plus any wait for result_ready, so at ss 1 it sets the pace; register writes wait
// for the back part to drain; reset: config returns to ss 1, 1024 by 1024, counters and
// queue clear; the column store is not cleared, every entry is written before it is read
`default_nettype none
module supersample_box_resolve import sbr_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  input  wire logic             pixel_valid,
  output logic                  pixel_ready,
  input  wire logic [RGB_W-1:0] pixel_rgb,
  output logic                  result_valid,
  input  wire logic             result_ready,
  output logic [RGB_W-1:0]      avg_rgb,
  output logic                  frame_last
);

  cmd_t        push_cmd, head;
  logic        q_push, q_pop, q_empty, q_full;
  logic [2:0]  ss_eff;
  front_stat_t fstat;
  back_stat_t  bstat;

  // a register write lands only once no command is queued or running
  assign cfg_ready = q_empty && !bstat.busy;

  sbr_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_rgb   (pixel_rgb),
    .q_full      (q_full),
    .pixel_ready (pixel_ready),
    .q_push      (q_push),
    .q_cmd       (push_cmd),
    .ss_eff      (ss_eff),
    .stat        (fstat)
  );

  sbr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  sbr_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk          (clk),
    .rst          (rst),
    .ss_eff       (ss_eff),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .avg_rgb      (avg_rgb),
    .frame_last   (frame_last),
    .stat         (bstat)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    fstat.push |-> !q_full) else $error("command pushed into a full queue");

  a_valid_only_showing: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (bstat.showing && bstat.busy)) else $error("result shown while back idle");

  a_cfg_restarts: assert property (@(posedge clk) disable iff (rst)
    (cfg_valid && cfg_ready && (cfg_index == REG_SS || cfg_index == REG_WIDTH
      || cfg_index == REG_HEIGHT)) |=> fstat.at_origin)
    else $error("register write did not restart the frame");

  a_pop_needs_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> (!bstat.busy && !q_empty)) else $error("queue popped while back busy");

endmodule
`default_nettype wire

### bench/supersample_box_resolve_test.sv
// supersample_box_resolve_test: self-checking bench for the supersample box resolve
// drives pixel and register items, predicts each averaged pixel and checks the results
// depends on sbr_pkg and supersample_box_resolve
`timescale 1ns / 1ps
module supersample_box_resolve_test import sbr_pkg::*; ();

  localparam int WIDTH_CAP    = 1024;
  localparam int HEIGHT_CAP   = 1024;
  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [RGB_W-1:0] rgb;
    logic             last;
  } avg_item_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [1:0]       cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic             pixel_valid;
  logic             pixel_ready;
  logic [RGB_W-1:0] pixel_rgb;
  logic             result_valid;
  logic             result_ready = 1'b0;
  logic [RGB_W-1:0] avg_rgb;
  logic             frame_last;

  supersample_box_resolve uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel_rgb    (pixel_rgb),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .avg_rgb      (avg_rgb),
    .frame_last   (frame_last)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [2:0]       ss_reg     = 3'd1;
  logic [CFG_W-1:0] width_reg  = 11'd1024;
  logic [CFG_W-1:0] height_reg = 11'd1024;
  int unsigned      lane_acc [3];
  int unsigned      col_acc [WIDTH_CAP][3];
  int unsigned      sub_x = 0, sub_y = 0, blk_x = 0, blk_y = 0;
  avg_item_t        expected_avg [$];

  int  errors        = 0;
  int  pixels_sent   = 0;
  int  avg_seen      = 0;
  int  frames_done   = 0;
  int  settings_used = 1;
  bit  no_gaps       = 1'b0;
  bit  hold_ask      = 1'b0;

  function automatic int unsigned bounded(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic void load_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    case (idx)
      REG_SS:     ss_reg = data[2:0];
      REG_WIDTH:  width_reg = data;
      REG_HEIGHT: height_reg = data;
      default:    return;
    endcase
    // any real register write starts a new frame
    sub_x = 0;
    sub_y = 0;
    blk_x = 0;
    blk_y = 0;
    for (int c = 0; c < 3; c++) lane_acc[c] = 0;
  endfunction

  // c = 0 is red, 1 green, 2 blue
  function automatic void resolve_pixel(input logic [RGB_W-1:0] rgb);
    int unsigned ss, w, h, n, sum;
    avg_item_t   item;
    ss = bounded(32'(ss_reg), MAX_SS);
    w = bounded(32'(width_reg), WIDTH_CAP);
    h = bounded(32'(height_reg), HEIGHT_CAP);
    for (int c = 0; c < 3; c++) begin
      if (sub_x == 0) lane_acc[c] = 32'(rgb[8*(2-c) +: 8]);
      else lane_acc[c] = lane_acc[c] + 32'(rgb[8*(2-c) +: 8]);
    end
    if (sub_x + 1 >= ss) begin
      for (int c = 0; c < 3; c++) begin
        sum = (sub_y == 0) ? lane_acc[c] : col_acc[blk_x][c] + lane_acc[c];
        if (sub_y + 1 >= ss) begin
          n = ss * ss;
          item.rgb[8*(2-c) +: 8] = 8'((2 * sum + n) / (2 * n));
        end else begin
          col_acc[blk_x][c] = sum;
        end
      end
      if (sub_y + 1 >= ss) begin
        item.last = (blk_x + 1 >= w) && (blk_y + 1 >= h);
        expected_avg = {expected_avg, item};
      end
      sub_x = 0;
      if (blk_x + 1 >= w) begin
        blk_x = 0;
        if (sub_y + 1 >= ss) begin
          sub_y = 0;
          blk_y = (blk_y + 1 >= h) ? 0 : blk_y + 1;
        end else begin
          sub_y++;
        end
      end else begin
        blk_x++;
      end
    end else begin
      sub_x++;
    end
  endfunction

  // mostly no gap, some short gaps, a few long ones
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [RGB_W-1:0] random_pixel();
    logic [RGB_W-1:0] p;
    p = RGB_W'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 3))
          0:       p[8*c +: 8] = 8'h00;
          1:       p[8*c +: 8] = 8'hFF;
          2:       p[8*c +: 8] = 8'h80;
          default: ;
        endcase
      end
    end
    return p;
  endfunction

  // receiver: random stalls, and a long hold-off when asked
  initial begin : receiver
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_ask) begin
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_ask = 1'b0;
      end else if (stall > 0) begin
        result_ready <= 1'b0;
        stall--;
      end else begin
        result_ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin : check_avg
    avg_item_t want;
    if (!rst && result_valid && result_ready) begin
      avg_seen++;
      if (frame_last === 1'b1) frames_done++;
      if (expected_avg.size() == 0) begin
        $display("%t: result with nothing expected: avg_rgb=%h frame_last=%b",
                 $time, avg_rgb, frame_last);
        errors++;
      end else begin
        want = expected_avg.pop_front();
        if (avg_rgb !== want.rgb) begin
          $display("%t: avg_rgb expected %h actual %h", $time, want.rgb, avg_rgb);
          errors++;
        end
        if (frame_last !== want.last) begin
          $display("%t: frame_last expected %b actual %b", $time, want.last, frame_last);
          errors++;
        end
      end
    end
  end

  // called at a falling edge; leaves valid high so a following item can go back to back
  task automatic send_pixel(input logic [RGB_W-1:0] rgb);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      pixel_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel_rgb <= rgb;
    do @(posedge clk); while (!pixel_ready);
    resolve_pixel(rgb);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    pixel_valid <= 1'b0;
    while (expected_avg.size() != 0) @(negedge clk);
    // stored column sums give no result but may still be in flight
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    load_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_shape(input int ss, input int w, input int h);
    write_reg(REG_SS, CFG_W'(ss));
    write_reg(REG_WIDTH, CFG_W'(w));
    write_reg(REG_HEIGHT, CFG_W'(h));
    settings_used++;
  endtask

  // reset config is ss 1 at 1024 by 1024: every pixel passes straight through
  task automatic test_reset_defaults();
    send_pixel(24'h000000);
    send_pixel(24'hFFFFFF);
    send_pixel(24'hA5A5A5);
    wait_idle();
  endtask

  task automatic test_box_rounding();
    set_shape(2, 1, 1);
    repeat (4) send_pixel(24'hFFFFFF);
    // red sum 1 rounds down, green and blue sums 2 sit on the half and round up
    send_pixel(24'h000000);
    send_pixel(24'h010201);
    send_pixel(24'h000000);
    send_pixel(24'h000001);
    wait_idle();
  endtask

  // factor zero and sizes zero all act as one
  task automatic test_zero_settings();
    set_shape(0, 0, 0);
    send_pixel(24'h123456);
    send_pixel(24'hFEDCBA);
    wait_idle();
  endtask

  // write to the unused index must not restart the frame
  task automatic test_ignored_index();
    set_shape(1, 2, 1);
    send_pixel(24'h0F0F0F);
    wait_idle();
    write_reg(REG_NONE, 11'h7FF);
    send_pixel(24'hF0F0F0);
    wait_idle();
  endtask

  task automatic test_output_hold();
    set_shape(1, 8, 4);
    hold_ask = 1'b1;
    repeat (32) send_pixel(random_pixel());
    wait_idle();
  endtask

  task automatic test_random_frames();
    int unsigned start, frame_px, count, ss_v, w_v, h_v;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_ITEMS) begin
      wait_idle();
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 9) != 0) begin
        ss_v = $urandom_range(0, 7);
        w_v = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
        h_v = $urandom_range(0, 3);
        write_reg(REG_SS, {8'($urandom), 3'(ss_v)});
        if ($urandom_range(0, 4) != 0) write_reg(REG_WIDTH, CFG_W'(w_v));
        if ($urandom_range(0, 4) != 0) write_reg(REG_HEIGHT, CFG_W'(h_v));
        if ($urandom_range(0, 5) == 0) write_reg(REG_NONE, CFG_W'($urandom));
        settings_used++;
        frame_px = bounded(width_reg, WIDTH_CAP) * bounded(height_reg, HEIGHT_CAP)
                   * bounded(ss_reg, MAX_SS) * bounded(ss_reg, MAX_SS);
        count = (frame_px <= 240) ? frame_px * $urandom_range(1, 2) : frame_px;
        // some frames are cut short and restarted by the next write
        if ($urandom_range(0, 3) == 0) count = $urandom_range(1, frame_px);
      end else begin
        count = $urandom_range(1, 40);
      end
      // keep the total close to the planned number of items
      if (count > RANDOM_ITEMS - (pixels_sent - start)) begin
        count = RANDOM_ITEMS - (pixels_sent - start);
      end
      repeat (count) send_pixel(random_pixel());
    end
    no_gaps = 1'b0;
    wait_idle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pixel_valid = 1'b0;
    pixel_rgb = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_box_rounding();
    test_zero_settings();
    test_ignored_index();
    test_output_hold();
    test_random_frames();
    $display("sent %0d pixels over %0d register settings", pixels_sent, settings_used);
    $display("checked %0d averaged pixels, %0d of them ending a frame", avg_seen, frames_done);
    if (errors == 0) begin
      $display("supersample_box_resolve_test OK");
    end else begin
      $display("supersample_box_resolve_test NOT OK");
    end
    $finish;
  end

  initial begin
    #8_000_000;
    $display("timeout after %0d pixels", pixels_sent);
    $display("supersample_box_resolve_test NOT OK");
    $finish;
  end

endmodule

### sim.f
src/sbr_pkg.sv
src/sbr_ram.sv
src/sbr_front.sv
src/sbr_queue.sv
src/sbr_back.sv
src/supersample_box_resolve.sv
bench/supersample_box_resolve_test.sv
